// ----- sv/vrelay_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vrelay_pkg
// Shared types and constants for the voltage relay with time delay.
// ----------------------------------------------------------------------------
package vrelay_pkg;

  // Field widths
  localparam int CH_W       = 2;
  localparam int SAMPLE_W   = 16;
  localparam int TICKS_W    = 16;
  localparam int CENTER_W   = 16;
  localparam int INV_K_W    = 26;
  localparam int MIN_TRIP_W = 16;
  localparam int TOTAL_W    = 8;
  localparam int ELAPSED_W  = 24;
  localparam int DEV_W      = 17;  // |2v - center| magnitude
  localparam int PROD_W     = ELAPSED_W + DEV_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 26;

  // Item kinds
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_TICK   = 1'b1;

  // Timing modes
  localparam logic [1:0] TM_NONE     = 2'd0;
  localparam logic [1:0] TM_DEFINITE = 2'd1;
  localparam logic [1:0] TM_INVERSE  = 2'd2;

  // Milliseconds per tick and saturation of the elapsed timer
  localparam logic [ELAPSED_W-1:0] TICK_MS     = ELAPSED_W'(10);
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};

  // Register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIMING_MODE  = 3'd0,
    REG_UPPER_LIMIT  = 3'd1,
    REG_LOWER_LIMIT  = 3'd2,
    REG_DEF_TICKS    = 3'd3,
    REG_CENTER_DBL   = 3'd4,
    REG_INV_CONSTANT = 3'd5,
    REG_MIN_TRIP_MS  = 3'd6
  } cfg_reg_e;

  // Register reset values
  localparam logic [1:0]                RST_TIMING_MODE = TM_NONE;
  localparam logic signed [SAMPLE_W-1:0] RST_UPPER_LIMIT = 16'sd9803;
  localparam logic signed [SAMPLE_W-1:0] RST_LOWER_LIMIT = 16'sd6536;
  localparam logic [TICKS_W-1:0]        RST_DEF_TICKS   = 16'd500;
  localparam logic [CENTER_W-1:0]       RST_CENTER_DBL  = 16'd16339;
  localparam logic [INV_K_W-1:0]        RST_INV_K       = 26'd16338500;
  localparam logic [MIN_TRIP_W-1:0]     RST_MIN_TRIP    = 16'd1000;

  typedef struct packed {
    logic [1:0]                 timing_mode;
    logic signed [SAMPLE_W-1:0] upper_limit;
    logic signed [SAMPLE_W-1:0] lower_limit;
    logic [TICKS_W-1:0]         definite_ticks;
    logic [CENTER_W-1:0]        center_doubled;
    logic [INV_K_W-1:0]         inverse_constant;
    logic [MIN_TRIP_W-1:0]      minimum_trip_ms;
  } cfg_t;

  typedef struct packed {
    logic                       mode;
    logic [CH_W-1:0]            channel;
    logic signed [SAMPLE_W-1:0] rms_value;
  } item_t;

  typedef struct packed {
    logic               alarm;
    logic               raise_active;
    logic               lower_active;
    logic [TOTAL_W-1:0] raise_total;
    logic [TOTAL_W-1:0] lower_total;
    logic               watching;
    logic [CH_W-1:0]    watched_channel;
  } result_t;

endpackage
`default_nettype wire

// ----- sv/vrelay_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vrelay_if
// Valid/ready channels of the relay: input items, results, register writes.
// ----------------------------------------------------------------------------

// Input item channel
interface vrelay_item_if import vrelay_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic [CH_W-1:0]            channel;
  logic signed [SAMPLE_W-1:0] rms_value;

  modport source (output valid, output mode, output channel, output rms_value,
                  input ready);
  modport sink   (input valid, input mode, input channel, input rms_value,
                  output ready);
endinterface

// Result channel
interface vrelay_result_if import vrelay_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               alarm;
  logic               raise_active;
  logic               lower_active;
  logic [TOTAL_W-1:0] raise_total;
  logic [TOTAL_W-1:0] lower_total;
  logic               watching;
  logic [CH_W-1:0]    watched_channel;

  modport source (output valid, output alarm, output raise_active,
                  output lower_active, output raise_total, output lower_total,
                  output watching, output watched_channel, input ready);
  modport sink   (input valid, input alarm, input raise_active,
                  input lower_active, input raise_total, input lower_total,
                  input watching, input watched_channel, output ready);
endinterface

// Register write channel
interface vrelay_cfg_if import vrelay_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- sv/vrelay_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vrelay_core
// Relay state and its combinational update for one item: sample store,
// excursion latch, definite and inverse timers, command flags and totals.
// ----------------------------------------------------------------------------
module vrelay_core import vrelay_pkg::*; #(
  parameter int CHANNELS = 3
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    step_i,    // process item_i this cycle
  input  wire item_t   item_i,
  input  wire cfg_t    cfg_i,
  output      result_t result_o   // state after item_i
);

  // State
  logic signed [SAMPLE_W-1:0] store_q [CHANNELS];
  logic signed [SAMPLE_W-1:0] store_d [CHANNELS];
  logic                       latched_q, latched_d;
  logic [CH_W-1:0]            watched_q, watched_d;
  logic                       running_q, running_d;
  logic [TICKS_W-1:0]         def_cnt_q, def_cnt_d;
  logic [ELAPSED_W-1:0]       elapsed_q, elapsed_d;
  logic                       trip_q, trip_d;
  logic                       alarm_q, alarm_d;
  logic                       raise_q, raise_d;
  logic                       lower_q, lower_d;
  logic [TOTAL_W-1:0]         raise_tot_q, raise_tot_d;
  logic [TOTAL_W-1:0]         lower_tot_q, lower_tot_d;

  // Per-channel band check and watched sample
  logic [CHANNELS-1:0]        store_oob;
  logic signed [SAMPLE_W-1:0] watched_v;

  always_comb begin
    watched_v = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      store_oob[i] = (store_q[i] > cfg_i.upper_limit) ||
                     (store_q[i] < cfg_i.lower_limit);
      if (32'(watched_q) == i) watched_v = store_q[i];
    end
  end

  // Inverse-time arithmetic on the watched sample
  logic                       w_over, w_under;
  logic [ELAPSED_W:0]         elapsed_sum;
  logic [ELAPSED_W-1:0]       elapsed_new;
  logic signed [DEV_W:0]      dev;
  logic [DEV_W-1:0]           dev_abs;
  logic [PROD_W-1:0]          product;
  logic                       trip_now;
  logic [TICKS_W:0]           def_cnt_inc;

  always_comb begin
    w_over      = watched_v > cfg_i.upper_limit;
    w_under     = watched_v < cfg_i.lower_limit;
    elapsed_sum = {1'b0, elapsed_q} + {1'b0, TICK_MS};
    elapsed_new = elapsed_sum[ELAPSED_W] ? ELAPSED_MAX : elapsed_sum[ELAPSED_W-1:0];
    dev         = $signed({watched_v[SAMPLE_W-1], watched_v, 1'b0}) -
                  $signed({2'b00, cfg_i.center_doubled});
    dev_abs     = dev[DEV_W] ? DEV_W'(-dev) : dev[DEV_W-1:0];
    product     = PROD_W'(elapsed_new) * PROD_W'(dev_abs);
    trip_now    = (dev_abs != '0) &&
                  (elapsed_new >= ELAPSED_W'(cfg_i.minimum_trip_ms)) &&
                  (product >= PROD_W'(cfg_i.inverse_constant));
    def_cnt_inc = {1'b0, def_cnt_q} + (TICKS_W+1)'(1);
  end

  // Next state for one item
  logic ch_ok;
  logic samp_oob;
  logic other_oob;

  always_comb begin
    store_d     = store_q;
    latched_d   = latched_q;
    watched_d   = watched_q;
    running_d   = running_q;
    def_cnt_d   = def_cnt_q;
    elapsed_d   = elapsed_q;
    trip_d      = trip_q;
    alarm_d     = alarm_q;
    raise_d     = raise_q;
    lower_d     = lower_q;
    raise_tot_d = raise_tot_q;
    lower_tot_d = lower_tot_q;

    ch_ok     = 32'(item_i.channel) < CHANNELS;
    samp_oob  = (item_i.rms_value > cfg_i.upper_limit) ||
                (item_i.rms_value < cfg_i.lower_limit);
    other_oob = 1'b0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (32'(item_i.channel) != i && store_oob[i]) other_oob = 1'b1;
    end

    if (item_i.mode == MODE_TICK) begin
      if (running_q && cfg_i.timing_mode == TM_DEFINITE) begin
        // Definite delay: act each time the tick count expires
        if (def_cnt_inc < {1'b0, cfg_i.definite_ticks}) begin
          def_cnt_d = def_cnt_inc[TICKS_W-1:0];
        end else begin
          def_cnt_d = '0;
          if (w_over) begin
            lower_d     = 1'b1;
            lower_tot_d = lower_tot_q + TOTAL_W'(1);
          end else if (w_under) begin
            raise_d     = 1'b1;
            raise_tot_d = raise_tot_q + TOTAL_W'(1);
          end else begin
            alarm_d = 1'b0;
            raise_d = 1'b0;
            lower_d = 1'b0;
          end
        end
      end else if (running_q && cfg_i.timing_mode == TM_INVERSE) begin
        // Inverse time: accumulate, trip on the tick after the limit
        if (!(w_over || w_under)) begin
          running_d = 1'b0;
          alarm_d   = 1'b0;
          raise_d   = 1'b0;
          lower_d   = 1'b0;
          def_cnt_d = '0;
          elapsed_d = '0;
          trip_d    = 1'b0;
        end else if (trip_q) begin
          if (w_over) begin
            lower_d     = 1'b1;
            lower_tot_d = lower_tot_q + TOTAL_W'(1);
          end else begin
            raise_d     = 1'b1;
            raise_tot_d = raise_tot_q + TOTAL_W'(1);
          end
          def_cnt_d = '0;
          elapsed_d = '0;
          trip_d    = 1'b0;
        end else begin
          elapsed_d = elapsed_new;
          trip_d    = trip_now;
        end
      end
    end else if (ch_ok) begin
      // Sample: store, latch first excursion, or release on return to band
      for (int i = 0; i < CHANNELS; i++) begin
        if (32'(item_i.channel) == i) store_d[i] = item_i.rms_value;
      end
      if (samp_oob) begin
        if (!latched_q) begin
          latched_d = 1'b1;
          alarm_d   = 1'b1;
          watched_d = item_i.channel;
          if (cfg_i.timing_mode == TM_DEFINITE || cfg_i.timing_mode == TM_INVERSE) begin
            running_d = 1'b1;
            def_cnt_d = '0;
            elapsed_d = '0;
            trip_d    = 1'b0;
          end
        end
      end else if (latched_q && watched_q == item_i.channel) begin
        latched_d = 1'b0;
        running_d = 1'b0;
        def_cnt_d = '0;
        elapsed_d = '0;
        trip_d    = 1'b0;
        if (!other_oob) begin
          alarm_d = 1'b0;
          raise_d = 1'b0;
          lower_d = 1'b0;
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) store_q[i] <= '0;
      latched_q   <= 1'b0;
      watched_q   <= '0;
      running_q   <= 1'b0;
      def_cnt_q   <= '0;
      elapsed_q   <= '0;
      trip_q      <= 1'b0;
      alarm_q     <= 1'b0;
      raise_q     <= 1'b0;
      lower_q     <= 1'b0;
      raise_tot_q <= '0;
      lower_tot_q <= '0;
    end else if (step_i) begin
      store_q     <= store_d;
      latched_q   <= latched_d;
      watched_q   <= watched_d;
      running_q   <= running_d;
      def_cnt_q   <= def_cnt_d;
      elapsed_q   <= elapsed_d;
      trip_q      <= trip_d;
      alarm_q     <= alarm_d;
      raise_q     <= raise_d;
      lower_q     <= lower_d;
      raise_tot_q <= raise_tot_d;
      lower_tot_q <= lower_tot_d;
    end
  end

  // Result reflects the state after the item
  always_comb begin
    result_o.alarm           = alarm_d;
    result_o.raise_active    = raise_d;
    result_o.lower_active    = lower_d;
    result_o.raise_total     = raise_tot_d;
    result_o.lower_total     = lower_tot_d;
    result_o.watching        = latched_d;
    result_o.watched_channel = watched_d;
  end

endmodule
`default_nettype wire

// ----- sv/voltage_relay_with_time_delay.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// voltage_relay_with_time_delay
// Over/under-voltage tap-change relay with definite or inverse time delay.
// ----------------------------------------------------------------------------
//  Port      Dir  Handshake      Carries
//  item_i    in   valid/ready    mode, channel, rms_value
//  result_o  out  valid/ready    alarm, raise/lower commands, totals, watch
//  cfg_i     in   valid/ready    register index, write data (always ready)
//
//  One item per cycle sustained while result_o is ready; a result is presented
//  once its item has passed the input register and then the update into the
//  result register, and a stalled result can hold back that update.
//  The update is one pass: a 24x17 multiply-compare for the inverse trip.
//  A stalled result holds the result register; the input register still
//  takes one more transaction before item_i.ready drops.
//  Reset restores register defaults and zeroes the sample store and state.
// ----------------------------------------------------------------------------
module voltage_relay_with_time_delay import vrelay_pkg::*; #(
  parameter int CHANNELS = 3
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  vrelay_item_if.sink     item_i,
  vrelay_result_if.source result_o,
  vrelay_cfg_if.sink      cfg_i
);

  // Configuration registers
  cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timing_mode      <= RST_TIMING_MODE;
      cfg_q.upper_limit      <= RST_UPPER_LIMIT;
      cfg_q.lower_limit      <= RST_LOWER_LIMIT;
      cfg_q.definite_ticks   <= RST_DEF_TICKS;
      cfg_q.center_doubled   <= RST_CENTER_DBL;
      cfg_q.inverse_constant <= RST_INV_K;
      cfg_q.minimum_trip_ms  <= RST_MIN_TRIP;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_TIMING_MODE:  cfg_q.timing_mode      <= cfg_i.data[1:0];
        REG_UPPER_LIMIT:  cfg_q.upper_limit      <= $signed(cfg_i.data[SAMPLE_W-1:0]);
        REG_LOWER_LIMIT:  cfg_q.lower_limit      <= $signed(cfg_i.data[SAMPLE_W-1:0]);
        REG_DEF_TICKS:    cfg_q.definite_ticks   <= cfg_i.data[TICKS_W-1:0];
        REG_CENTER_DBL:   cfg_q.center_doubled   <= cfg_i.data[CENTER_W-1:0];
        REG_INV_CONSTANT: cfg_q.inverse_constant <= cfg_i.data[INV_K_W-1:0];
        REG_MIN_TRIP_MS:  cfg_q.minimum_trip_ms  <= cfg_i.data[MIN_TRIP_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  item_t   item_q;
  logic    item_valid_q;
  result_t res_q;
  result_t res_d;
  logic    res_valid_q;
  logic    advance;

  assign advance      = item_valid_q && (!res_valid_q || result_o.ready);
  assign item_i.ready = !item_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (item_i.valid && item_i.ready) begin
      item_valid_q <= 1'b1;
    end else if (advance) begin
      item_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      item_q.mode      <= item_i.mode;
      item_q.channel   <= item_i.channel;
      item_q.rms_value <= item_i.rms_value;
    end
  end

  // Relay update
  vrelay_core #(
    .CHANNELS (CHANNELS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (item_q),
    .cfg_i    (cfg_q),
    .result_o (res_d)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) res_q <= res_d;
  end

  assign result_o.valid           = res_valid_q;
  assign result_o.alarm           = res_q.alarm;
  assign result_o.raise_active    = res_q.raise_active;
  assign result_o.lower_active    = res_q.lower_active;
  assign result_o.raise_total     = res_q.raise_total;
  assign result_o.lower_total     = res_q.lower_total;
  assign result_o.watching        = res_q.watching;
  assign result_o.watched_channel = res_q.watched_channel;

endmodule
`default_nettype wire
